@@ src/gtw_pkg.sv @@
// Shared types and constants for the Gaussian tap weight generator.
`default_nettype none
package gtw_pkg;
    localparam int VAR_W   = 16;
    localparam int E_W     = 33;
    localparam int TOT_W   = 38;
    localparam int DIV_N   = 49;
    localparam int DVS_W   = TOT_W;
    localparam int CNT_W   = $clog2(DIV_N + 1);
    localparam int K_W     = 4;
    localparam int N_W     = 17;

    localparam logic [VAR_W-1:0] VAR_MIN = 16'd41;
    localparam logic [VAR_W-1:0] VAR_MAX = 16'd40960;
    localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
    localparam logic [K_W-1:0]   SERIES_LAST = 4'd12;

    // ceil(2^s/k) with s = 32 + ceil(log2 k): floor(x*RCP >> s) == floor(x/k) for 32-bit x
    localparam logic [32:0] RCP_POW2 = 33'h1_0000_0000;
    localparam logic [32:0] RCP_3    = 33'(((65'd1 << 34) + 65'd2) / 65'd3);
    localparam logic [32:0] RCP_5    = 33'(((65'd1 << 35) + 65'd4) / 65'd5);
    localparam logic [32:0] RCP_6    = 33'(((65'd1 << 35) + 65'd5) / 65'd6);
    localparam logic [32:0] RCP_7    = 33'(((65'd1 << 35) + 65'd6) / 65'd7);
    localparam logic [32:0] RCP_9    = 33'(((65'd1 << 36) + 65'd8) / 65'd9);
    localparam logic [32:0] RCP_10   = 33'(((65'd1 << 36) + 65'd9) / 65'd10);
    localparam logic [32:0] RCP_11   = 33'(((65'd1 << 36) + 65'd10) / 65'd11);
    localparam logic [32:0] RCP_12   = 33'(((65'd1 << 36) + 65'd11) / 65'd12);

    typedef struct packed {
        logic             valid;
        logic [VAR_W-1:0] vc;
    } t_queue;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ src/gaussian_tap_weight_generator.sv @@
// Top level of the Gaussian tap weight generator.
// Each variance word (unsigned Q4.12, clamped to 0.01..10.0) yields NUM_TAPS weight
// words in tap order, tlast on the final one. The back end runs one shared serial
// divider; the time per item is set by that divider and the exp series up to the
// t^12 term, and receiver stalls add to it.
// A two-word input queue takes new variances while a run is in progress, and the
// output register holds a weight while the next one is computed.
`default_nettype none
module gaussian_tap_weight_generator
    import gtw_pkg::*;
#(
    parameter int NUM_TAPS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] variance
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [2:0] tap_index, [18:3] weight, [23:19] zero
    output logic             m_axis_tlast
);
    t_queue   w_head;
    logic     w_pop;
    t_div_req w_req;
    t_div_rsp w_rsp;

    gtw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_pop         (w_pop),
        .o_head        (w_head)
    );

    gtw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    gtw_back #(.NUM_TAPS(NUM_TAPS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_div_req     (w_req),
        .i_div_rsp     (w_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire

@@ src/gtw_front.sv @@
// Input side: accepts variance words, clamps them and queues them for the back end.
`default_nettype none
module gtw_front
    import gtw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [VAR_W-1:0] s_axis_tdata,
    input  wire logic             i_pop,
    output t_queue                o_head
);
    logic [VAR_W-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic [VAR_W-1:0] w_clamp;
    logic             w_push, w_pop;

    always_comb begin
        w_clamp = s_axis_tdata;
        if (s_axis_tdata < VAR_MIN) w_clamp = VAR_MIN;
        if (s_axis_tdata > VAR_MAX) w_clamp = VAR_MAX;
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign w_pop  = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.vc    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_clamp;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

@@ src/gtw_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gtw_div
    import gtw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);
    logic [DVS_W-1:0] r_rem;
    logic [DIV_N-1:0] r_dvd, r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DVS_W:0]   w_sh, w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_dvd[DIV_N-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
            r_dvd <= {r_dvd[DIV_N-2:0], 1'b0};
            r_quo <= {r_quo[DIV_N-2:0], w_ge};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done holds until the next start
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(DIV_N - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ src/gtw_back.sv @@
// Back end: computes raw tap weights and their total, then normalizes and emits them.
`default_nettype none
module gtw_back
    import gtw_pkg::*;
#(
    parameter int NUM_TAPS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_queue     i_head,
    output logic       o_pop,
    output t_div_req   o_div_req,
    input  t_div_rsp   i_div_rsp,
    output logic       m_axis_tvalid,
    input  wire logic  m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic       m_axis_tlast
);
    localparam int IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam logic [IDX_W-1:0] TAP_LAST = IDX_W'(NUM_TAPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XST  = 4'd1;
    localparam logic [3:0] S_XDIV = 4'd2;
    localparam logic [3:0] S_Y    = 4'd3;
    localparam logic [3:0] S_T    = 4'd4;
    localparam logic [3:0] S_S0   = 4'd5;
    localparam logic [3:0] S_SA   = 4'd6;
    localparam logic [3:0] S_SB   = 4'd7;
    localparam logic [3:0] S_E    = 4'd8;
    localparam logic [3:0] S_NST  = 4'd9;
    localparam logic [3:0] S_NDIV = 4'd10;

    logic [3:0]       r_state;
    logic [IDX_W-1:0] r_tap;
    logic [VAR_W-1:0] r_vc;
    logic [32:0]      r_y;
    logic [31:0]      r_t, r_term;
    logic [N_W-1:0]   r_n;
    logic [E_W-1:0]   r_acc;
    logic [63:0]      r_prod;
    logic [K_W-1:0]   r_k;
    logic [E_W-1:0]   r_e [NUM_TAPS];
    logic [TOT_W-1:0] r_total;

    logic             r_ovalid, r_olast;
    logic [2:0]       r_oidx;
    logic [15:0]      r_ow;

    logic [9:0]       w_i;
    logic [9:0]       w_rr;
    logic [63:0]      w_ym;
    logic [47:0]      w_tm;
    logic [31:0]      w_ph, w_q;
    logic [32:0]      w_rm;
    logic [5:0]       w_rs;
    logic [64:0]      w_qm;
    logic [E_W-1:0]   w_e;
    logic [IDX_W+2:0] w_tix;
    logic             w_out_free;
    logic             w_load;
    logic [15:0]      w_wsat;

    assign w_i  = 10'(r_tap);
    assign w_rr = (w_i << 2) * (w_i + 10'd1);
    assign w_ym = 64'(i_div_rsp.quotient[31:0]) * 64'(LOG2E_Q30);
    assign w_tm = 48'(r_y[15:0]) * 48'(LN2_Q32);
    assign w_ph = r_prod[63:32];
    assign w_e  = (r_n >= N_W'(32)) ? '0 : (r_acc >> r_n[4:0]);
    assign w_tix = (IDX_W + 3)'(r_tap);
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_load = (r_state == S_NDIV) && i_div_rsp.done && w_out_free;
    assign w_wsat = i_div_rsp.quotient[16] ? 16'hFFFF : i_div_rsp.quotient[15:0];

    // series term divide by k as reciprocal multiply
    always_comb begin
        case (r_k)
            4'd2:    begin w_rm = RCP_POW2; w_rs = 6'd33; end
            4'd3:    begin w_rm = RCP_3;    w_rs = 6'd34; end
            4'd4:    begin w_rm = RCP_POW2; w_rs = 6'd34; end
            4'd5:    begin w_rm = RCP_5;    w_rs = 6'd35; end
            4'd6:    begin w_rm = RCP_6;    w_rs = 6'd35; end
            4'd7:    begin w_rm = RCP_7;    w_rs = 6'd35; end
            4'd8:    begin w_rm = RCP_POW2; w_rs = 6'd35; end
            4'd9:    begin w_rm = RCP_9;    w_rs = 6'd36; end
            4'd10:   begin w_rm = RCP_10;   w_rs = 6'd36; end
            4'd11:   begin w_rm = RCP_11;   w_rs = 6'd36; end
            4'd12:   begin w_rm = RCP_12;   w_rs = 6'd36; end
            default: begin w_rm = RCP_POW2; w_rs = 6'd32; end
        endcase
        w_qm = 65'(w_ph) * 65'(w_rm);
        w_q  = 32'(w_qm >> w_rs);
    end

    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = DIV_N'({w_rr, 27'b0});
        o_div_req.divisor  = DVS_W'(r_vc);
        case (r_state)
            S_XST: o_div_req.start = 1'b1;
            S_NST: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DIV_N'({r_e[r_tap], 16'b0}) + DIV_N'(r_total >> 1);
                o_div_req.divisor  = r_total;
            end
            default: o_div_req.start = 1'b0;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_ow, r_oidx};
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_head.valid) begin
                r_vc    <= i_head.vc;
                r_total <= '0;
            end
            S_Y: r_y <= 33'((w_ym + 64'd536870912) >> 30);
            S_T: begin
                r_t <= w_tm[47:16];
                r_n <= r_y[32:16];
            end
            S_S0: begin
                r_term <= r_t;
                r_acc  <= E_W'(33'h1_0000_0000 - {1'b0, r_t});
                r_k    <= 4'd2;
            end
            S_SA: r_prod <= 64'(r_term) * 64'(r_t);
            S_SB: begin
                r_term <= w_q;
                r_acc  <= r_k[0] ? r_acc - E_W'(w_q) : r_acc + E_W'(w_q);
                r_k    <= r_k + 1'b1;
            end
            S_E: begin
                r_e[r_tap] <= w_e;
                r_total <= r_total + ((r_tap == '0) ? TOT_W'(w_e) : TOT_W'({w_e, 1'b0}));
            end
            default: r_k <= r_k;
        endcase
        if (w_load) begin
            r_oidx  <= w_tix[2:0];
            r_ow    <= w_wsat;
            r_olast <= (r_tap == TAP_LAST);
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tap    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_head.valid) begin
                    r_tap   <= '0;
                    r_state <= S_XST;
                end
                S_XST:  r_state <= S_XDIV;
                S_XDIV: if (i_div_rsp.done) r_state <= S_Y;
                S_Y:    r_state <= S_T;
                S_T:    r_state <= S_S0;
                S_S0:   r_state <= S_SA;
                S_SA:   r_state <= S_SB;
                S_SB:   r_state <= (r_k == SERIES_LAST) ? S_E : S_SA;
                S_E: begin
                    if (r_tap == TAP_LAST) begin
                        r_tap   <= '0;
                        r_state <= S_NST;
                    end else begin
                        r_tap   <= r_tap + 1'b1;
                        r_state <= S_XST;
                    end
                end
                S_NST:  r_state <= S_NDIV;
                S_NDIV: if (w_load) begin
                    if (r_tap == TAP_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_tap   <= r_tap + 1'b1;
                        r_state <= S_NST;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
